>>> hw/rtl/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by every module of the block.
package wsd_pkg;

  localparam int LENGTH_WIDTH_DEF = 64;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam int HDR_CNT_W = 4;

  localparam logic [7:0] RSV_BITS    = 8'h70;
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  localparam logic [HDR_CNT_W-1:0] EXT16_BYTES = 4'd2;
  localparam logic [HDR_CNT_W-1:0] EXT64_BYTES = 4'd8;
  localparam logic [HDR_CNT_W-1:0] KEY_BYTES   = 4'd4;

  localparam logic [3:0] OP_DATA_MAX = 4'd2;
  localparam logic [3:0] OP_CTRL_MIN = 4'd8;
  localparam logic [3:0] OP_CTRL_MAX = 4'd10;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_MASK,
    PH_DATA,
    PH_HALT
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_END,
    KIND_ERROR
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_RSV,
    ERR_FRAG_CTRL,
    ERR_OPCODE
  } err_t;

  // One classified request from the parser to the output side.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] raw;
    logic [7:0] key;
    logic [3:0] opcode;
    logic       fin;
    logic       last;
    err_t       err;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Push side of the queue as seen by the parser.
  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

endpackage

>>> hw/rtl/websocket_frame_deframer.sv
// WebSocket frame deframer, receive side: one received byte per cycle in,
// header parsed, payload unmasked. Accepts a byte every cycle while the
// four-entry request queue has room; that queue fills only while the result
// side is stalled. Each result passes from the byte that causes it through
// a queue write, then the output register. A protocol error gives one error
// result and the parser then takes and drops every byte until reset.
// Depends on wsd_pkg, wsd_front, wsd_queue and wsd_back.
module websocket_frame_deframer #(
  parameter int LENGTH_WIDTH = wsd_pkg::LENGTH_WIDTH_DEF,
  parameter int QUEUE_DEPTH  = wsd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] data_byte,
  output logic [3:0] frame_opcode,
  output logic       final_fragment,
  output logic       last_in_frame,
  output logic [1:0] error_code
);
  import wsd_pkg::*;

  push_t  req;
  logic   room;
  logic   rd_valid;
  entry_t rd_entry;
  logic   pop;

  wsd_front #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .room     (room),
    .req      (req)
  );

  wsd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .room     (room),
    .rd_valid (rd_valid),
    .rd_entry (rd_entry),
    .pop      (pop)
  );

  wsd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .rd_valid       (rd_valid),
    .rd_entry       (rd_entry),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .data_byte      (data_byte),
    .frame_opcode   (frame_opcode),
    .final_fragment (final_fragment),
    .last_in_frame  (last_in_frame),
    .error_code     (error_code)
  );

endmodule

>>> hw/rtl/wsd_front.sv
// Header parser: accepts received bytes, tracks the frame header and turns
// each payload byte, each empty frame's end and each header error into a queue entry. Depends on wsd_pkg.
module wsd_front #(
  parameter int LENGTH_WIDTH = wsd_pkg::LENGTH_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      rx_byte,
  input  logic            room,
  output wsd_pkg::push_t  req
);
  import wsd_pkg::*;

  phase_t                  phase, phase_next;
  logic [HDR_CNT_W-1:0]    hdr_count, hdr_count_next;
  logic [HDR_CNT_W-1:0]    count_inc;
  logic [3:0]              cur_opcode, cur_opcode_next;
  logic                    cur_fin, cur_fin_next;
  logic                    is_masked, is_masked_next;
  logic                    long_len, long_len_next;
  logic [31:0]             mask_key, mask_key_next;
  logic [LENGTH_WIDTH-1:0] bytes_left, bytes_left_next;
  logic [LENGTH_WIDTH-1:0] len_val;
  logic [1:0]              mask_index, mask_index_next;
  logic                    take;
  logic                    len_done;
  logic                    hdr_end;
  err_t                    hdr_err;
  logic [7:0]              key_byte;

  assign in_ready  = room;
  assign take      = in_valid && in_ready;
  assign count_inc = hdr_count + 1'b1;

  always_comb begin
    unique case (mask_index)
      2'd0: key_byte = mask_key[31:24];
      2'd1: key_byte = mask_key[23:16];
      2'd2: key_byte = mask_key[15:8];
      2'd3: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    if ((rx_byte & RSV_BITS) != 8'd0) begin
      hdr_err = ERR_RSV;
    end else if (rx_byte[3:0] <= OP_DATA_MAX) begin
      hdr_err = ERR_NONE;
    end else if (rx_byte[3:0] >= OP_CTRL_MIN && rx_byte[3:0] <= OP_CTRL_MAX) begin
      hdr_err = rx_byte[7] ? ERR_NONE : ERR_FRAG_CTRL;
    end else begin
      hdr_err = ERR_OPCODE;
    end
  end

  always_comb begin
    phase_next      = phase;
    hdr_count_next  = hdr_count;
    cur_opcode_next = cur_opcode;
    cur_fin_next    = cur_fin;
    is_masked_next  = is_masked;
    long_len_next   = long_len;
    mask_key_next   = mask_key;
    bytes_left_next = bytes_left;
    mask_index_next = mask_index;
    len_val         = bytes_left;
    len_done        = 1'b0;
    hdr_end         = 1'b0;
    req.push         = 1'b0;
    req.entry.kind   = KIND_DATA;
    req.entry.raw    = 8'd0;
    req.entry.key    = 8'd0;
    req.entry.opcode = cur_opcode;
    req.entry.fin    = cur_fin;
    req.entry.last   = 1'b0;
    req.entry.err    = ERR_NONE;

    if (take) begin
      unique case (phase)
        PH_HDR0: begin
          cur_fin_next    = rx_byte[7];
          cur_opcode_next = rx_byte[3:0];
          if (hdr_err != ERR_NONE) begin
            phase_next       = PH_HALT;
            req.push         = 1'b1;
            req.entry.kind   = KIND_ERROR;
            req.entry.opcode = rx_byte[3:0];
            req.entry.fin    = rx_byte[7];
            req.entry.err    = hdr_err;
          end else begin
            phase_next = PH_HDR1;
          end
        end
        PH_HDR1: begin
          is_masked_next = rx_byte[7];
          long_len_next  = (rx_byte[6:0] == LEN_CODE_64);
          mask_key_next  = 32'd0;
          hdr_count_next = '0;
          if (rx_byte[6:0] >= LEN_CODE_16) begin
            phase_next      = PH_EXTLEN;
            bytes_left_next = '0;
          end else begin
            len_val         = {{(LENGTH_WIDTH-7){1'b0}}, rx_byte[6:0]};
            bytes_left_next = len_val;
            len_done        = 1'b1;
          end
        end
        PH_EXTLEN: begin
          if (bytes_left[LENGTH_WIDTH-1 -: 8] != 8'd0) begin
            len_val = '1;
          end else begin
            len_val = {bytes_left[LENGTH_WIDTH-9:0], rx_byte};
          end
          bytes_left_next = len_val;
          hdr_count_next  = count_inc;
          if (count_inc >= (long_len ? EXT64_BYTES : EXT16_BYTES)) begin
            len_done = 1'b1;
          end
        end
        PH_MASK: begin
          mask_key_next  = {mask_key[23:0], rx_byte};
          hdr_count_next = count_inc;
          if (count_inc >= KEY_BYTES) begin
            hdr_end = 1'b1;
          end
        end
        PH_DATA: begin
          mask_index_next  = mask_index + 1'b1;
          bytes_left_next  = bytes_left - 1'b1;
          req.push         = 1'b1;
          req.entry.kind   = KIND_DATA;
          req.entry.raw    = rx_byte;
          req.entry.key    = is_masked ? key_byte : 8'd0;
          req.entry.last   = (bytes_left_next == '0);
          if (bytes_left_next == '0) begin
            phase_next = PH_HDR0;
          end
        end
        PH_HALT: begin
        end
        default: begin
          phase_next = PH_HALT;
        end
      endcase

      if (len_done) begin
        if (is_masked_next) begin
          phase_next     = PH_MASK;
          hdr_count_next = '0;
        end else begin
          hdr_end = 1'b1;
        end
      end

      if (hdr_end) begin
        mask_index_next = 2'd0;
        if (len_val == '0) begin
          phase_next     = PH_HDR0;
          req.push       = 1'b1;
          req.entry.kind = KIND_END;
          req.entry.last = 1'b1;
        end else begin
          phase_next = PH_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HDR0;
      hdr_count  <= '0;
      cur_opcode <= 4'd0;
      cur_fin    <= 1'b0;
      is_masked  <= 1'b0;
      long_len   <= 1'b0;
      mask_key   <= 32'd0;
      bytes_left <= '0;
      mask_index <= 2'd0;
    end else begin
      phase      <= phase_next;
      hdr_count  <= hdr_count_next;
      cur_opcode <= cur_opcode_next;
      cur_fin    <= cur_fin_next;
      is_masked  <= is_masked_next;
      long_len   <= long_len_next;
      mask_key   <= mask_key_next;
      bytes_left <= bytes_left_next;
      mask_index <= mask_index_next;
    end
  end

endmodule

>>> hw/rtl/wsd_queue.sv
// Short first-in first-out queue of classified requests between the
// parser and the output stage. Depends on wsd_pkg.
module wsd_queue #(
  parameter int DEPTH = wsd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  wsd_pkg::push_t   req,
  output logic             room,
  output logic             rd_valid,
  output wsd_pkg::entry_t  rd_entry,
  input  logic             pop
);
  import wsd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  entry_t            slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push, do_pop;

  assign room     = (count != FULL_CNT);
  assign rd_valid = (count != '0);
  assign rd_entry = slots[rd_ptr];
  assign do_push  = req.push && room;
  assign do_pop   = pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= req.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/wsd_back.sv
// Output stage: takes classified requests from the queue, removes the mask
// and holds each result in the output register. Depends on wsd_pkg.
module wsd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_valid,
  input  wsd_pkg::entry_t  rd_entry,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       kind,
  output logic [7:0]       data_byte,
  output logic [3:0]       frame_opcode,
  output logic             final_fragment,
  output logic             last_in_frame,
  output logic [1:0]       error_code
);
  import wsd_pkg::*;

  entry_t     held;
  logic [7:0] held_data;

  assign pop = rd_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      held      <= rd_entry;
      held_data <= rd_entry.raw ^ rd_entry.key;
    end
  end

  assign kind           = held.kind;
  assign data_byte      = held_data;
  assign frame_opcode   = held.opcode;
  assign final_fragment = held.fin;
  assign last_in_frame  = held.last;
  assign error_code     = held.err;

endmodule
